@@ sv/sphc_pkg.sv @@
package sphc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CW            = 32;
   localparam int RAD_W         = 31;
   localparam int SCL_W         = 24;
   localparam int R_W           = 55;
   localparam int RSUM_W        = R_W + 1;
   localparam int MAG_W         = 33;
   localparam int SQ_W          = 2 * MAG_W;
   localparam int SUM_W         = SQ_W + 2;
   localparam int ROOT_W        = 34;
   localparam int REM_W         = ROOT_W + 1;
   localparam int NORM_SHIFT    = 30;
   localparam int Q_W           = NORM_SHIFT + 1;
   localparam int DEP_W         = RSUM_W + 1;
   localparam int RLO_W         = 28;
   localparam int RHI_W         = R_W - RLO_W;
   localparam int PLO_W         = Q_W + RLO_W;
   localparam int PHI_W         = Q_W + RHI_W;
   localparam int PROD_W        = Q_W + R_W;
   localparam int CON_W         = R_W + 2;

   typedef struct packed {
      logic signed [CW-1:0]    a_center_x;
      logic signed [CW-1:0]    a_center_y;
      logic signed [CW-1:0]    a_center_z;
      logic        [RAD_W-1:0] a_radius;
      logic        [SCL_W-1:0] a_scale;
      logic signed [CW-1:0]    b_center_x;
      logic signed [CW-1:0]    b_center_y;
      logic signed [CW-1:0]    b_center_z;
      logic        [RAD_W-1:0] b_radius;
      logic        [SCL_W-1:0] b_scale;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic        [CW-1:0] depth;
      logic signed [CW-1:0] normal_x;
      logic signed [CW-1:0] normal_y;
      logic signed [CW-1:0] normal_z;
      logic signed [CW-1:0] contact_a_x;
      logic signed [CW-1:0] contact_a_y;
      logic signed [CW-1:0] contact_a_z;
      logic signed [CW-1:0] contact_b_x;
      logic signed [CW-1:0] contact_b_y;
      logic signed [CW-1:0] contact_b_z;
   } rsp_type;

   typedef struct packed {
      logic [2:0][CW-1:0]    ca;
      logic [2:0][CW-1:0]    cb;
      logic [2:0]            dneg;
      logic [2:0][MAG_W-1:0] mag;
      logic [R_W-1:0]        ra;
      logic [R_W-1:0]        rb;
   } carry_type;

   typedef struct packed {
      carry_type            c;
      logic [2:0][SQ_W-1:0] sq;
   } sqr_type;

   typedef struct packed {
      carry_type           c;
      logic [SUM_W-1:0]    s;
      logic [RSUM_W-1:0]   rsum;
      logic [ROOT_W-1:0]   res;
      logic [SUM_W-1:0]    resq;
   } root_type;

   typedef struct packed {
      carry_type             c;
      logic                  hit;
      logic [DEP_W-1:0]      depth;
      logic                  dzero;
      logic [ROOT_W-1:0]     d;
      logic [2:0][REM_W-1:0] rem;
      logic [2:0][Q_W-1:0]   q;
   } div_type;

   typedef struct packed {
      logic [2:0][CW-1:0]    ca;
      logic [2:0][CW-1:0]    cb;
      logic [2:0]            dneg;
      logic                  hit;
      logic [DEP_W-1:0]      depth;
      logic [2:0][CW-1:0]    nrm;
      logic [2:0][PLO_W-1:0] plo_a;
      logic [2:0][PHI_W-1:0] phi_a;
      logic [2:0][PLO_W-1:0] plo_b;
      logic [2:0][PHI_W-1:0] phi_b;
   } mul_type;

   typedef struct packed {
      logic [2:0][CW-1:0]  ca;
      logic [2:0][CW-1:0]  cb;
      logic [2:0]          dneg;
      logic                hit;
      logic [DEP_W-1:0]    depth;
      logic [2:0][CW-1:0]  nrm;
      logic [2:0][R_W-1:0] off_a;
      logic [2:0][R_W-1:0] off_b;
   } off_type;

   function automatic logic [CW-1:0] sat32(input logic signed [CON_W-1:0] v);
      logic signed [CON_W-1:0] hi;
      logic signed [CON_W-1:0] lo;
      hi = CON_W'(2147483647);
      lo = -CON_W'(64'sd2147483648);
      if (v > hi) begin
         sat32 = 32'h7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = v[CW-1:0];
      end
   endfunction

endpackage

@@ sv/sphere_sphere_contact.sv @@
// Sphere pair contact test, fully pipelined: while rsp_ready is high, one pair
// may enter every clock and one result leaves every clock. The latency is set
// by the bit-per-stage square root of the squared centre distance (34 stages)
// and the bit-per-stage division that normalises the direction (31 stages,
// three lanes side by side). A two-entry output buffer keeps the pipeline
// moving while one result waits to be taken; the pipeline stalls only when
// both entries are held.
module sphere_sphere_contact #(
   parameter int FRAC_BITS = sphc_pkg::FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sphc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sphc_pkg::rsp_type rsp_data
);

   localparam int ROOT_W = sphc_pkg::ROOT_W;
   localparam int Q_W    = sphc_pkg::Q_W;

   logic en;
   logic push;
   logic pop;

   sphc_pkg::carry_type s1_in, s1_ff;
   logic                v1_ff;
   sphc_pkg::sqr_type   s2_in, s2_ff;
   logic                v2_ff;
   sphc_pkg::root_type  rt_in [0:ROOT_W];
   sphc_pkg::root_type  rt_ff [0:ROOT_W];
   logic                rtv_ff [0:ROOT_W];
   sphc_pkg::div_type   dv_in [0:Q_W];
   sphc_pkg::div_type   dv_ff [0:Q_W];
   logic                dvv_ff [0:Q_W];
   sphc_pkg::mul_type   m1_in, m1_ff;
   logic                m1v_ff;
   sphc_pkg::off_type   m2_in, m2_ff;
   logic                m2v_ff;
   sphc_pkg::rsp_type   res_new;
   sphc_pkg::rsp_type   slot0_in, slot0_ff, slot1_in, slot1_ff;
   logic [1:0]          occ_in, occ_ff;

   assign en        = (occ_ff != 2'd2) || rsp_ready;
   assign req_ready = en;
   assign pop       = rsp_valid && rsp_ready;
   assign push      = en && m2v_ff;

   // centre differences and raw radius products
   always_comb begin
      logic [2:0][sphc_pkg::CW-1:0] ca;
      logic [2:0][sphc_pkg::CW-1:0] cb;
      logic [sphc_pkg::MAG_W-1:0]   diff;
      ca = {req_data.a_center_z, req_data.a_center_y, req_data.a_center_x};
      cb = {req_data.b_center_z, req_data.b_center_y, req_data.b_center_x};
      s1_in.ca = ca;
      s1_in.cb = cb;
      for (int i = 0; i < 3; i++) begin
         diff = {ca[i][sphc_pkg::CW-1], ca[i]} - {cb[i][sphc_pkg::CW-1], cb[i]};
         s1_in.dneg[i] = diff[sphc_pkg::MAG_W-1];
         s1_in.mag[i]  = diff[sphc_pkg::MAG_W-1] ? -diff : diff;
      end
      s1_in.ra = sphc_pkg::R_W'(req_data.a_radius) * sphc_pkg::R_W'(req_data.a_scale);
      s1_in.rb = sphc_pkg::R_W'(req_data.b_radius) * sphc_pkg::R_W'(req_data.b_scale);
   end

   // squares, radius scaling
   always_comb begin
      s2_in.c    = s1_ff;
      s2_in.c.ra = s1_ff.ra >> FRAC_BITS;
      s2_in.c.rb = s1_ff.rb >> FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         s2_in.sq[i] = sphc_pkg::SQ_W'(s1_ff.mag[i]) * sphc_pkg::SQ_W'(s1_ff.mag[i]);
      end
   end

   // sum of squares into the root pipeline
   always_comb begin
      rt_in[0].c    = s2_ff.c;
      rt_in[0].s    = sphc_pkg::SUM_W'(s2_ff.sq[0]) + sphc_pkg::SUM_W'(s2_ff.sq[1])
                    + sphc_pkg::SUM_W'(s2_ff.sq[2]);
      rt_in[0].rsum = sphc_pkg::RSUM_W'(s2_ff.c.ra) + sphc_pkg::RSUM_W'(s2_ff.c.rb);
      rt_in[0].res  = '0;
      rt_in[0].resq = '0;
   end

   genvar k;
   generate
      for (k = 0; k < ROOT_W; k++) begin : g_root
         localparam int B = ROOT_W - 1 - k;
         logic [sphc_pkg::SUM_W:0] cand_sq;
         always_comb begin
            rt_in[k+1] = rt_ff[k];
            cand_sq = {1'b0, rt_ff[k].resq}
                    + ((sphc_pkg::SUM_W+1)'(rt_ff[k].res) << (B + 1))
                    + ((sphc_pkg::SUM_W+1)'(1) << (2 * B));
            if (cand_sq <= {1'b0, rt_ff[k].s}) begin
               rt_in[k+1].res[B] = 1'b1;
               rt_in[k+1].resq   = cand_sq[sphc_pkg::SUM_W-1:0];
            end
         end
      end
   endgenerate

   // depth and divider set-up
   always_comb begin
      logic [ROOT_W-1:0] d;
      d              = rt_ff[ROOT_W].res;
      dv_in[0].c     = rt_ff[ROOT_W].c;
      dv_in[0].d     = d;
      dv_in[0].dzero = (d == '0);
      dv_in[0].depth = sphc_pkg::DEP_W'(rt_ff[ROOT_W].rsum) - sphc_pkg::DEP_W'(d);
      dv_in[0].hit   = !dv_in[0].depth[sphc_pkg::DEP_W-1] && (dv_in[0].depth != '0);
      for (int i = 0; i < 3; i++) begin
         dv_in[0].rem[i] = sphc_pkg::REM_W'(rt_ff[ROOT_W].c.mag[i]);
      end
      dv_in[0].q = '0;
   end

   genvar j;
   generate
      for (j = 0; j < Q_W; j++) begin : g_div
         localparam int QB = Q_W - 1 - j;
         logic [2:0][sphc_pkg::REM_W-1:0] t;
         always_comb begin
            dv_in[j+1] = dv_ff[j];
            for (int i = 0; i < 3; i++) begin
               t[i] = (j == 0) ? dv_ff[j].rem[i] : (dv_ff[j].rem[i] << 1);
               if (t[i] >= sphc_pkg::REM_W'(dv_ff[j].d)) begin
                  dv_in[j+1].rem[i]  = t[i] - sphc_pkg::REM_W'(dv_ff[j].d);
                  dv_in[j+1].q[i][QB] = 1'b1;
               end else begin
                  dv_in[j+1].rem[i] = t[i];
               end
            end
         end
      end
   endgenerate

   // signed normal and split radius products
   always_comb begin
      logic [Q_W-1:0] nq;
      m1_in.ca    = dv_ff[Q_W].c.ca;
      m1_in.cb    = dv_ff[Q_W].c.cb;
      m1_in.dneg  = dv_ff[Q_W].c.dneg;
      m1_in.hit   = dv_ff[Q_W].hit;
      m1_in.depth = dv_ff[Q_W].depth;
      for (int i = 0; i < 3; i++) begin
         nq = dv_ff[Q_W].dzero ? '0 : dv_ff[Q_W].q[i];
         m1_in.nrm[i] = dv_ff[Q_W].c.dneg[i] ? -sphc_pkg::CW'(nq) : sphc_pkg::CW'(nq);
         m1_in.plo_a[i] = sphc_pkg::PLO_W'(nq)
                        * sphc_pkg::PLO_W'(dv_ff[Q_W].c.ra[sphc_pkg::RLO_W-1:0]);
         m1_in.phi_a[i] = sphc_pkg::PHI_W'(nq)
                        * sphc_pkg::PHI_W'(dv_ff[Q_W].c.ra[sphc_pkg::R_W-1:sphc_pkg::RLO_W]);
         m1_in.plo_b[i] = sphc_pkg::PLO_W'(nq)
                        * sphc_pkg::PLO_W'(dv_ff[Q_W].c.rb[sphc_pkg::RLO_W-1:0]);
         m1_in.phi_b[i] = sphc_pkg::PHI_W'(nq)
                        * sphc_pkg::PHI_W'(dv_ff[Q_W].c.rb[sphc_pkg::R_W-1:sphc_pkg::RLO_W]);
      end
   end

   // recombine partial products, drop the Q2.30 fraction
   always_comb begin
      logic [sphc_pkg::PROD_W-1:0] pa;
      logic [sphc_pkg::PROD_W-1:0] pb;
      m2_in.ca    = m1_ff.ca;
      m2_in.cb    = m1_ff.cb;
      m2_in.dneg  = m1_ff.dneg;
      m2_in.hit   = m1_ff.hit;
      m2_in.depth = m1_ff.depth;
      m2_in.nrm   = m1_ff.nrm;
      for (int i = 0; i < 3; i++) begin
         pa = sphc_pkg::PROD_W'(m1_ff.plo_a[i])
            + (sphc_pkg::PROD_W'(m1_ff.phi_a[i]) << sphc_pkg::RLO_W);
         pb = sphc_pkg::PROD_W'(m1_ff.plo_b[i])
            + (sphc_pkg::PROD_W'(m1_ff.phi_b[i]) << sphc_pkg::RLO_W);
         m2_in.off_a[i] = pa[sphc_pkg::NORM_SHIFT +: sphc_pkg::R_W];
         m2_in.off_b[i] = pb[sphc_pkg::NORM_SHIFT +: sphc_pkg::R_W];
      end
   end

   // contact points and result assembly
   always_comb begin
      logic signed [sphc_pkg::CON_W-1:0] cav;
      logic signed [sphc_pkg::CON_W-1:0] cbv;
      logic signed [sphc_pkg::CON_W-1:0] oa;
      logic signed [sphc_pkg::CON_W-1:0] ob;
      logic [2:0][sphc_pkg::CW-1:0]      pa;
      logic [2:0][sphc_pkg::CW-1:0]      pb;
      for (int i = 0; i < 3; i++) begin
         cav = sphc_pkg::CON_W'($signed(m2_ff.ca[i]));
         cbv = sphc_pkg::CON_W'($signed(m2_ff.cb[i]));
         oa  = $signed(sphc_pkg::CON_W'(m2_ff.off_a[i]));
         ob  = $signed(sphc_pkg::CON_W'(m2_ff.off_b[i]));
         pa[i] = sphc_pkg::sat32(m2_ff.dneg[i] ? cav + oa : cav - oa);
         pb[i] = sphc_pkg::sat32(m2_ff.dneg[i] ? cbv - ob : cbv + ob);
      end
      res_new = '0;
      if (m2_ff.hit) begin
         res_new.hit         = 1'b1;
         res_new.depth       = (m2_ff.depth[sphc_pkg::DEP_W-1:sphc_pkg::CW] != '0)
                             ? '1 : m2_ff.depth[sphc_pkg::CW-1:0];
         res_new.normal_x    = m2_ff.nrm[0];
         res_new.normal_y    = m2_ff.nrm[1];
         res_new.normal_z    = m2_ff.nrm[2];
         res_new.contact_a_x = pa[0];
         res_new.contact_a_y = pa[1];
         res_new.contact_a_z = pa[2];
         res_new.contact_b_x = pb[0];
         res_new.contact_b_y = pb[1];
         res_new.contact_b_z = pb[2];
      end
   end

   // two-entry output buffer
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      occ_in   = occ_ff;
      case ({push, pop})
         2'b10: begin
            if (occ_ff == 2'd0) begin
               slot0_in = res_new;
            end else begin
               slot1_in = res_new;
            end
            occ_in = occ_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            occ_in   = occ_ff - 2'd1;
         end
         2'b11: begin
            if (occ_ff == 2'd1) begin
               slot0_in = res_new;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = res_new;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = (occ_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         m1v_ff <= 1'b0;
         m2v_ff <= 1'b0;
         occ_ff <= 2'd0;
      end else begin
         occ_ff <= occ_in;
         if (en) begin
            v1_ff  <= req_valid;
            v2_ff  <= v1_ff;
            m1v_ff <= dvv_ff[Q_W];
            m2v_ff <= m1v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   genvar p;
   generate
      for (p = 0; p <= ROOT_W; p++) begin : g_rt_reg
         always_ff @(posedge clock) begin
            if (reset) begin
               rtv_ff[p] <= 1'b0;
            end else if (en) begin
               rtv_ff[p] <= (p == 0) ? v2_ff : rtv_ff[(p == 0) ? 0 : p - 1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               rt_ff[p] <= rt_in[p];
            end
         end
      end
      for (p = 0; p <= Q_W; p++) begin : g_dv_reg
         always_ff @(posedge clock) begin
            if (reset) begin
               dvv_ff[p] <= 1'b0;
            end else if (en) begin
               dvv_ff[p] <= (p == 0) ? rtv_ff[ROOT_W] : dvv_ff[(p == 0) ? 0 : p - 1];
            end
         end
         always_ff @(posedge clock) begin
            if (en) begin
               dv_ff[p] <= dv_in[p];
            end
         end
      end
   endgenerate

   assert property (@(posedge clock) disable iff (reset) occ_ff != 2'd3)
      else $error("output buffer count out of range");

   assert property (@(posedge clock) disable iff (reset)
      (occ_ff == 2'd2 && !rsp_ready) |-> !req_ready)
      else $error("pipeline advanced with a full output buffer");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.depth == '0 && rsp_data.normal_x == '0
         && rsp_data.normal_y == '0 && rsp_data.normal_z == '0
         && rsp_data.contact_a_x == '0 && rsp_data.contact_b_x == '0))
      else $error("miss result carries non-zero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.normal_x <= 32'sd1073741824
         && rsp_data.normal_x >= -32'sd1073741824
         && rsp_data.normal_y <= 32'sd1073741824
         && rsp_data.normal_y >= -32'sd1073741824))
      else $error("normal component above unit length");

   assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (occ_ff == $past(occ_ff) - 2'd1))
      else $error("output buffer lost track of a taken item");

endmodule

@@ tb/sv/sphere_sphere_contact_tb.sv @@
`timescale 1ns / 100ps

module sphere_sphere_contact_tb;

   localparam int NUM_RANDOM = 1300;
   localparam int TAIL_ITEMS = 200;
   localparam int LONG_HOLD  = 300;
   localparam int DRAIN      = 100;

   typedef struct {
      sphc_pkg::req_type pair;
      bit                typed;
      sphc_pkg::rsp_type known;
   } row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   sphc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   sphc_pkg::rsp_type rsp_data;

   sphc_pkg::rsp_type contact_q[$];
   row_type           rows[$];
   int                n_sent;
   int                n_hits;
   int                n_misses;
   int                n_errors;
   bit                hold_done;

   sphere_sphere_contact dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // sign(n) * floor(|n| * r / 2^30)
   function automatic longint normal_offset(input longint n, input logic [63:0] r);
      logic [127:0] prod;
      logic [63:0]  m;
      prod = 128'(n < 0 ? -n : n) * 128'(r);
      m = 64'(prod >> sphc_pkg::NORM_SHIFT);
      return n < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic sphc_pkg::rsp_type predict_contact(input sphc_pkg::req_type r);
      longint            ca[3], cb[3], df[3], nrm[3];
      logic [31:0]       pa[3], pb[3];
      logic [63:0]       ra, rb, d, mag, cand, q;
      logic [127:0]      sum;
      longint            dep;
      sphc_pkg::rsp_type o;
      o = '0;
      ca[0] = r.a_center_x; ca[1] = r.a_center_y; ca[2] = r.a_center_z;
      cb[0] = r.b_center_x; cb[1] = r.b_center_y; cb[2] = r.b_center_z;
      ra = (64'(r.a_radius) * 64'(r.a_scale)) >> sphc_pkg::FRAC_BITS_DEF;
      rb = (64'(r.b_radius) * 64'(r.b_scale)) >> sphc_pkg::FRAC_BITS_DEF;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         df[i] = ca[i] - cb[i];
         mag = df[i] < 0 ? -df[i] : df[i];
         sum += 128'(mag) * 128'(mag);
      end
      d = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = d | (64'd1 << b);
         if (128'(cand) * 128'(cand) <= sum) d = cand;
      end
      dep = longint'(ra + rb) - longint'(d);
      if (dep <= 0) return o;
      for (int i = 0; i < 3; i++) begin
         if (d == 0) begin
            nrm[i] = 0;
         end else begin
            mag = df[i] < 0 ? -df[i] : df[i];
            q = (mag << sphc_pkg::NORM_SHIFT) / d;
            nrm[i] = df[i] < 0 ? -longint'(q) : longint'(q);
         end
         pa[i] = clamp32(ca[i] - normal_offset(nrm[i], ra));
         pb[i] = clamp32(cb[i] + normal_offset(nrm[i], rb));
      end
      o.hit = 1'b1;
      o.depth = dep > 64'sh0_FFFF_FFFF ? 32'hFFFF_FFFF : dep[31:0];
      o.normal_x = nrm[0][31:0]; o.normal_y = nrm[1][31:0]; o.normal_z = nrm[2][31:0];
      o.contact_a_x = pa[0]; o.contact_a_y = pa[1]; o.contact_a_z = pa[2];
      o.contact_b_x = pb[0]; o.contact_b_y = pb[1]; o.contact_b_z = pb[2];
      return o;
   endfunction

   function automatic sphc_pkg::req_type make_pair(input logic signed [31:0] ax, ay, az,
                                         input logic [30:0] ar, input logic [23:0] as,
                                         input logic signed [31:0] bx, by, bz,
                                         input logic [30:0] br, input logic [23:0] bs);
      sphc_pkg::req_type p;
      p.a_center_x = ax; p.a_center_y = ay; p.a_center_z = az;
      p.a_radius = ar; p.a_scale = as;
      p.b_center_x = bx; p.b_center_y = by; p.b_center_z = bz;
      p.b_radius = br; p.b_scale = bs;
      return p;
   endfunction

   function automatic void add_row(input sphc_pkg::req_type pair, input bit typed,
                                   input sphc_pkg::rsp_type known);
      row_type row;
      row.pair  = pair;
      row.typed = typed;
      row.known = known;
      rows.insert(rows.size(), row);
   endfunction

   function automatic logic signed [31:0] near(input logic signed [31:0] c, input int span);
      return c + $signed(32'($urandom_range(0, 2 * span))) - span;
   endfunction

   function automatic sphc_pkg::req_type random_pair();
      sphc_pkg::req_type p;
      logic [319:0]      bits;
      int                kind;
      int                span;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      p = bits[$bits(sphc_pkg::req_type)-1:0];
      kind = $urandom_range(0, 9);
      span = 1 << $urandom_range(4, 22);
      if (kind <= 5) begin
         p.b_center_x = near(p.a_center_x, span);
         p.b_center_y = near(p.a_center_y, span);
         p.b_center_z = near(p.a_center_z, span);
         p.a_radius = 31'($urandom_range(0, span));
         p.b_radius = 31'($urandom_range(0, span));
         p.a_scale = 24'($urandom_range(0, 1 << 18));
         p.b_scale = 24'($urandom_range(0, 1 << 18));
      end else if (kind == 6) begin
         p.b_center_x = p.a_center_x;
         p.b_center_y = p.a_center_y;
         p.b_center_z = p.a_center_z;
      end
      return p;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $error("%s: expected %h, got %h", name, e, a);
         n_errors++;
      end
   endtask

   task automatic send_pair(input sphc_pkg::req_type p, input sphc_pkg::rsp_type want,
                            input bit gaps);
      int n;
      if (gaps && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      contact_q.insert(contact_q.size(), want);
      n_sent++;
      if (want.hit) n_hits++; else n_misses++;
   endtask

   initial begin
      sphc_pkg::rsp_type zero;
      sphc_pkg::rsp_type r;
      sphc_pkg::req_type p;
      zero = '0;
      n_sent = 0; n_hits = 0; n_misses = 0; n_errors = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;

      add_row(make_pair(0, 0, 0, '0, '0, 0, 0, 0, '0, '0), 1'b1, zero);
      r = zero; r.hit = 1'b1; r.depth = 32'h0002_0000;
      r.contact_a_x = 32'h0001_0000; r.contact_a_y = -32'sd5; r.contact_a_z = 0;
      r.contact_b_x = 32'h0001_0000; r.contact_b_y = -32'sd5; r.contact_b_z = 0;
      add_row(make_pair(32'h0001_0000, -5, 0, 31'h1_0000, 24'h01_0000,
                        32'h0001_0000, -5, 0, 31'h1_0000, 24'h01_0000), 1'b1, r);
      // saturated depth, coincident centres at the origin
      r = zero; r.hit = 1'b1; r.depth = 32'hFFFF_FFFF;
      add_row(make_pair(0, 0, 0, '1, '1, 0, 0, 0, '1, '1), 1'b1, r);
      r = zero; r.hit = 1'b1; r.depth = 32'h0001_0000;
      r.contact_a_x = 32'h8000_0000; r.contact_a_y = 32'h8000_0000;
      r.contact_a_z = 32'h8000_0000;
      r.contact_b_x = 32'h8000_0000; r.contact_b_y = 32'h8000_0000;
      r.contact_b_z = 32'h8000_0000;
      add_row(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        31'h1_0000, 24'h01_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, '0, '0), 1'b1, r);
      // far apart at opposite corners, no hit
      add_row(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        31'h1_0000, 24'h01_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 31'h1_0000, 24'h01_0000), 1'b1, zero);
      // touching exactly: depth zero is no hit
      add_row(make_pair(32'h0002_0000, 0, 0, 31'h1_0000, 24'h01_0000,
                        0, 0, 0, 31'h1_0000, 24'h01_0000), 1'b1, zero);
      add_row(make_pair(32'h0001_8000, 0, 0, 31'h1_0000, 24'h01_0000,
                        0, 0, 0, 31'h1_0000, 24'h01_0000), 1'b0, zero);
      add_row(make_pair(0, -32'sh0001_0000, 0, 31'h1_0000, 24'h02_0000,
                        0, 0, 0, 31'h1_0000, 24'h00_8000), 1'b0, zero);
      add_row(make_pair(3, 4, 12, 31'h10, 24'h01_0000, 0, 0, 0, 31'h5, 24'h01_0000),
              1'b0, zero);
      add_row(make_pair(-7, 9, -2, 31'h40, 24'h01_0000, 5, -3, 8, 31'h7, 24'hFF_FFFF),
              1'b0, zero);
      // wide contact: huge radii push the contact points out of range
      add_row(make_pair(32'h7FFF_FFFF, 0, 0, '1, '1, 32'h7FFF_0000, 0, 0, '1, '1),
              1'b0, zero);
      add_row(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 0, '1, '1,
                        32'h8000_0100, 32'h7FFF_FF00, 5, '1, '1), 1'b0, zero);
      add_row(make_pair(0, 0, 32'h8000_0000, 31'h4000_0000, 24'h80_0000,
                        0, 0, 32'h7FFF_FFFF, 31'h4000_0000, 24'h80_0000), 1'b0, zero);
      add_row(make_pair(100, 100, 100, '0, '1, 99, 100, 100, 31'h2, 24'h01_0000),
              1'b0, zero);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         send_pair(rows[i].pair, rows[i].typed ? rows[i].known : predict_contact(rows[i].pair),
                   1'b1);
         if (rows[i].typed && rows[i].known !== predict_contact(rows[i].pair)) begin
            $error("row %0d: typed expectation disagrees with prediction", i);
            n_errors++;
         end
      end
      for (int i = 0; i < NUM_RANDOM; i++) begin
         p = random_pair();
         send_pair(p, predict_contact(p), i < NUM_RANDOM - TAIL_ITEMS);
      end
      req_valid <= 1'b0;

      while (contact_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("%0d sphere pairs sent: %0d contacts, %0d separated, incl. a %0d-cycle stall",
               n_sent, n_hits, n_misses, LONG_HOLD);
      if (n_errors == 0 && contact_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      int n;
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!hold_done && n_sent > 100) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            n = 0;
            while (n < LONG_HOLD) begin
               @(posedge clock);
               n++;
            end
         end else if (n_sent > NUM_RANDOM - TAIL_ITEMS || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      sphc_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (contact_q.size() == 0) begin
            $error("result with no pair outstanding");
            n_errors++;
         end else begin
            e = contact_q.pop_front();
            compare_field("hit", 32'(e.hit), 32'(rsp_data.hit));
            compare_field("depth", e.depth, rsp_data.depth);
            compare_field("normal_x", e.normal_x, rsp_data.normal_x);
            compare_field("normal_y", e.normal_y, rsp_data.normal_y);
            compare_field("normal_z", e.normal_z, rsp_data.normal_z);
            compare_field("contact_a_x", e.contact_a_x, rsp_data.contact_a_x);
            compare_field("contact_a_y", e.contact_a_y, rsp_data.contact_a_y);
            compare_field("contact_a_z", e.contact_a_z, rsp_data.contact_a_z);
            compare_field("contact_b_x", e.contact_b_x, rsp_data.contact_b_x);
            compare_field("contact_b_y", e.contact_b_y, rsp_data.contact_b_y);
            compare_field("contact_b_z", e.contact_b_z, rsp_data.contact_b_z);
         end
      end
   end

   initial begin
      #3000000;
      $display("timeout with %0d results outstanding", contact_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/sphc_pkg.sv
sv/sphere_sphere_contact.sv
tb/sv/sphere_sphere_contact_tb.sv
